[hw/rtl/tmsf_pkg.sv]
// Shared constants for the trimmed-mean smoothing filter.
package tmsf_pkg;

  localparam int MV_BITS            = 14;
  localparam int MV_FULL_SCALE      = 9900;
  localparam int SMOOTH_PREV_WEIGHT = 7;
  localparam int SMOOTH_NEW_WEIGHT  = 3;
  localparam int SMOOTH_DIV         = 10;

endpackage

[hw/rtl/trimmed_mean_smoothing_filter.sv]
// Top level of the trimmed-mean battery filter with exponential smoothing.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_stall    sample
//   output   out        out_valid/out_stall  filtered_raw, voltage_mv
//
// One sample accepted per cycle while in_stall is low; a request is offered once
// the last sample of its burst has passed the input reg, scale multiply, accumulate,
// weight, divide-by-ten multiply, millivolt multiply and output reg.
// Reset clears the burst accumulators and the smoothed level; no sweep.
// in_stall is high while the skid slot is full, which happens when a request arrives
// while the output is stalled; the pipeline then holds until the output is taken.
module trimmed_mean_smoothing_filter import tmsf_pkg::*; #(
  parameter int SAMPLES_PER_BURST = 9,
  parameter int ADC_BITS          = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADC_BITS-1:0] filtered_raw,
  output logic [MV_BITS-1:0]  voltage_mv
);

  logic                en;
  logic                s0_valid;
  logic [ADC_BITS-1:0] s0_sample;
  logic                mean_valid;
  logic [ADC_BITS-1:0] mean;
  logic                res_valid;
  logic [ADC_BITS-1:0] res_raw;
  logic [MV_BITS-1:0]  res_mv;

  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sample <= sample;
    end
  end

  tmsf_burst_accum #(
    .SAMPLES_PER_BURST(SAMPLES_PER_BURST),
    .ADC_BITS(ADC_BITS)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .en(en),
    .sample_valid(s0_valid),
    .sample(s0_sample),
    .mean_valid(mean_valid),
    .mean(mean)
  );

  tmsf_smoother #(
    .ADC_BITS(ADC_BITS)
  ) u_smoother (
    .clk(clk),
    .rst(rst),
    .en(en),
    .mean_valid(mean_valid),
    .mean(mean),
    .res_valid(res_valid),
    .res_raw(res_raw),
    .res_mv(res_mv)
  );

  tmsf_out_queue #(
    .ADC_BITS(ADC_BITS)
  ) u_out_queue (
    .clk(clk),
    .rst(rst),
    .res_valid(res_valid),
    .res_raw(res_raw),
    .res_mv(res_mv),
    .en(en),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_raw(filtered_raw),
    .voltage_mv(voltage_mv)
  );

endmodule

[hw/rtl/tmsf_burst_accum.sv]
// Per-sample scaling by reciprocal multiply and burst sum, min and max tracking.
module tmsf_burst_accum #(
  parameter int SAMPLES_PER_BURST = 9,
  parameter int ADC_BITS          = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                sample_valid,
  input  logic [ADC_BITS-1:0] sample,
  output logic                mean_valid,
  output logic [ADC_BITS-1:0] mean
);

  localparam int TrimDiv   = SAMPLES_PER_BURST - 2;
  localparam int DivShift  = ADC_BITS + 4;
  localparam int MultW     = ADC_BITS + 5;
  localparam int ProdW     = ADC_BITS + MultW;
  localparam int SumW      = ADC_BITS + 2;
  localparam int CntW      = $clog2(SAMPLES_PER_BURST);
  localparam longint unsigned DivMult =
    ((64'd1 << DivShift) + 64'(TrimDiv) - 64'd1) / 64'(TrimDiv);
  localparam longint unsigned RawMask = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned MinReset = RawMask / 64'(TrimDiv);
  localparam logic [CntW-1:0] LastCount = CntW'(SAMPLES_PER_BURST - 1);

  logic [ProdW-1:0]    prod;
  logic                s1_valid;
  logic [ADC_BITS-1:0] s1_scaled;

  logic [CntW-1:0]     burst_count;
  logic [SumW-1:0]     scaled_sum;
  logic [ADC_BITS-1:0] burst_min;
  logic [ADC_BITS-1:0] burst_max;

  logic [SumW-1:0]     scaled_sum_next;
  logic [ADC_BITS-1:0] burst_min_next;
  logic [ADC_BITS-1:0] burst_max_next;
  logic [SumW-1:0]     trimmed;
  logic                last;

  assign prod = ProdW'(sample) * ProdW'(MultW'(DivMult));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_scaled <= prod[DivShift +: ADC_BITS];
    end
  end

  always_comb begin
    scaled_sum_next = scaled_sum + SumW'(s1_scaled);
    burst_min_next  = (s1_scaled < burst_min) ? s1_scaled : burst_min;
    burst_max_next  = (s1_scaled > burst_max) ? s1_scaled : burst_max;
    trimmed         = scaled_sum_next - SumW'(burst_min_next) - SumW'(burst_max_next);
    last            = (burst_count == LastCount);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count <= '0;
      scaled_sum  <= '0;
      burst_min   <= ADC_BITS'(MinReset);
      burst_max   <= '0;
      mean_valid  <= 1'b0;
    end else if (en) begin
      mean_valid <= s1_valid && last;
      if (s1_valid) begin
        if (last) begin
          burst_count <= '0;
          scaled_sum  <= '0;
          burst_min   <= ADC_BITS'(MinReset);
          burst_max   <= '0;
        end else begin
          burst_count <= burst_count + CntW'(1);
          scaled_sum  <= scaled_sum_next;
          burst_min   <= burst_min_next;
          burst_max   <= burst_max_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid && last) begin
      mean <= trimmed[ADC_BITS-1:0];
    end
  end

endmodule

[hw/rtl/tmsf_smoother.sv]
// Exponential smoothing of the burst mean and millivolt conversion.
module tmsf_smoother import tmsf_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                mean_valid,
  input  logic [ADC_BITS-1:0] mean,
  output logic                res_valid,
  output logic [ADC_BITS-1:0] res_raw,
  output logic [MV_BITS-1:0]  res_mv
);

  localparam int TW        = ADC_BITS + 4;
  localparam int DivShift  = TW + 4;
  localparam int MultW     = ADC_BITS + 5;
  localparam int ProdW     = TW + MultW;
  localparam int MvProdW   = ADC_BITS + MV_BITS;
  localparam longint unsigned DivMult =
    ((64'd1 << DivShift) + 64'(SMOOTH_DIV) - 64'd1) / 64'(SMOOTH_DIV);

  logic                s3_valid;
  logic                s3_load;
  logic [ADC_BITS-1:0] s3_mean;
  logic [TW-1:0]       s3_t;
  logic                s4_valid;
  logic [ADC_BITS-1:0] smoothed_level;
  logic [ADC_BITS-1:0] smoothed_level_next;
  logic [TW-1:0]       weighted;
  logic [ProdW-1:0]    div_prod;
  logic [MvProdW-1:0]  mv_prod;

  assign weighted = TW'(smoothed_level) * TW'(SMOOTH_PREV_WEIGHT)
                  + TW'(mean) * TW'(SMOOTH_NEW_WEIGHT);
  assign div_prod = ProdW'(s3_t) * ProdW'(MultW'(DivMult));
  assign smoothed_level_next = s3_load ? s3_mean : div_prod[DivShift +: ADC_BITS];
  assign mv_prod = MvProdW'(smoothed_level) * MvProdW'(MV_FULL_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid       <= 1'b0;
      s4_valid       <= 1'b0;
      res_valid      <= 1'b0;
      smoothed_level <= '0;
    end else if (en) begin
      s3_valid  <= mean_valid;
      s4_valid  <= s3_valid;
      res_valid <= s4_valid;
      if (s3_valid) begin
        smoothed_level <= smoothed_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t    <= weighted;
      s3_mean <= mean;
      s3_load <= (smoothed_level == '0);
      res_raw <= smoothed_level;
      res_mv  <= mv_prod[ADC_BITS +: MV_BITS];
    end
  end

endmodule

[hw/rtl/tmsf_out_queue.sv]
// Output register with one skid slot; holds the pipeline when the slot is full.
module tmsf_out_queue import tmsf_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  logic [ADC_BITS-1:0] res_raw,
  input  logic [MV_BITS-1:0]  res_mv,
  output logic                en,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADC_BITS-1:0] filtered_raw,
  output logic [MV_BITS-1:0]  voltage_mv
);

  logic                skid_full;
  logic [ADC_BITS-1:0] skid_raw;
  logic [MV_BITS-1:0]  skid_mv;
  logic                push;
  logic                take;

  assign en   = !skid_full;
  assign push = res_valid && en;
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        filtered_raw <= skid_raw;
        voltage_mv   <= skid_mv;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        filtered_raw <= res_raw;
        voltage_mv   <= res_mv;
      end else begin
        skid_raw <= res_raw;
        skid_mv  <= res_mv;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid slot full with no request in the output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !out_stall) |=> !skid_full)
    else $error("skid slot not drained after output taken");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !skid_full && out_valid && out_stall) |=> skid_full)
    else $error("request pushed while output stalled was not held in skid slot");

endmodule
